[rtl/core/ledfx_pkg.sv]
// shared constants, codes and color helpers for the led strip effect pixel generator
package ledfx_pkg;

   localparam int MAX_PIXELS_DEF = 256;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [8:0]  PIXEL_COUNT_RST   = 9'd256;
   localparam logic [7:0]  RAINBOW_SPEED_RST = 8'd1;
   localparam logic [9:0]  WIPE_SPEED_RST    = 10'd1;
   localparam logic [9:0]  WIPE_SPEED_MAX    = 10'd1000;
   localparam logic [23:0] BASE_COLOR_RST    = 24'hFF_FFFF;

   localparam logic [7:0] LEVEL_FULL  = 8'd255;
   localparam logic [7:0] WHEEL_THIRD = 8'd85;
   localparam logic [7:0] WHEEL_2THRD = 8'd170;

   // store entry: {on, brightness, red, green, blue}
   localparam int          ENTRY_W   = 33;
   localparam logic [32:0] ENTRY_RST = {1'b0, 8'd0, 8'hFF, 8'hFF, 8'hFF};

   typedef enum logic [2:0] {
      MODE_OFF     = 3'd0,
      MODE_RAINBOW = 3'd1,
      MODE_WIPE    = 3'd2,
      MODE_SOLID   = 3'd3,
      MODE_MANUAL  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_EFFECT_MODE     = 3'd0,
      CSR_PIXEL_COUNT     = 3'd1,
      CSR_RAINBOW_SPEED   = 3'd2,
      CSR_RAINBOW_FORWARD = 3'd3,
      CSR_WIPE_SPEED      = 3'd4,
      CSR_WIPE_FORWARD    = 3'd5,
      CSR_BASE_COLOR      = 3'd6
   } csr_index_type;

   localparam logic FUNC_WRITE = 1'b1;

   function automatic logic [23:0] color_wheel(input logic [7:0] pos);
      logic [7:0] p;
      logic [7:0] x3;
      logic [23:0] rgb;
      if (pos < WHEEL_THIRD) begin
         p = pos;
      end else if (pos < WHEEL_2THRD) begin
         p = pos - WHEEL_THIRD;
      end else begin
         p = pos - WHEEL_2THRD;
      end
      x3 = 8'((10'(p) << 1) + 10'(p));
      if (pos < WHEEL_THIRD) begin
         rgb = {x3, LEVEL_FULL - x3, 8'd0};
      end else if (pos < WHEEL_2THRD) begin
         rgb = {LEVEL_FULL - x3, 8'd0, x3};
      end else begin
         rgb = {8'd0, x3, LEVEL_FULL - x3};
      end
      return rgb;
   endfunction

   // exact floor(x / 255) for any 16-bit x below 65280, whose quotient fits in 8 bits
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'd1;
      t = t + (t >> 8);
      return t[15:8];
   endfunction

endpackage

[rtl/core/ledfx_ram.sv]
// generic single write port ram with registered read
module ledfx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/led_strip_effect_pixel_generator.sv]
// led strip effect pixel generator: renders one pixel color per request beat
// steps: solid/wipe/off go straight to done, rainbow runs a 16-step serial divide,
// manual reads the store then runs an 8-step serial multiply; a frame-end wipe beat adds
// two serial modulo passes (DW = 16 at 256 pixels); writes go to the store from idle
// one render in work at a time, a write every cycle while idle, result held on stall
// reset clears control and config, then a pass over all MAX_PIXELS entries clears the store
module led_strip_effect_pixel_generator #(
   parameter int MAX_PIXELS = ledfx_pkg::MAX_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic                             csr_we,
   input  logic [ledfx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ledfx_pkg::CSR_DATA_W-1:0]  csr_wdata,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_pixel_index,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_in_brightness,
   input  logic        req_in_pixel_on,
   input  logic        req_frame_last,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_index,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_out_frame_end
);

   localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW   = ($clog2(MAX_PIXELS + 1) > 9) ? $clog2(MAX_PIXELS + 1) : 9;
   localparam int RW   = CW + 1;
   localparam int DW   = (CW + 1 > 16) ? CW + 1 : 16;
   localparam int CNTW = $clog2(DW);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_MLOAD = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_WSTEP = 8'b0010_0000,
      ST_WPOS  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [2:0]  mode_ff, mode_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  rspeed_ff, rspeed_in;
   logic        rfwd_ff, rfwd_in;
   logic [9:0]  wspeed_ff, wspeed_in;
   logic        wfwd_ff, wfwd_in;
   logic [23:0] base_ff, base_in;

   logic [11:0]   phase_ff, phase_in;
   logic [AW-1:0] pos_ff, pos_in;

   logic [7:0]  idx_ff, idx_in;
   logic        last_ff, last_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic [15:0] acc_r_ff, acc_r_in, acc_g_ff, acc_g_in, acc_b_ff, acc_b_in;
   logic [7:0]  mc_r_ff, mc_r_in, mc_g_ff, mc_g_in, mc_b_ff, mc_b_in;
   logic [7:0]  mbr_ff, mbr_in;

   logic [DW-1:0]   dvd_ff, dvd_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [7:0]      quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_index_ff, out_index_in;
   logic [7:0]  out_red_ff, out_red_in, out_green_ff, out_green_in, out_blue_ff, out_blue_in;
   logic        out_end_ff, out_end_in;

   logic [CW-1:0]  n_eff;
   logic           req_accept;
   logic           req_in_range;
   logic [AW+7:0]  req_addr_ext;
   logic [AW-1:0]  req_addr;
   logic [RW-1:0]  div_t;
   logic           div_ge;
   logic [RW-1:0]  div_rem;
   logic [7:0]     quo_next;
   logic           div_last;
   logic [9:0]     wspeed_eff;
   logic [7:0]     rspeed_eff;
   logic [CW-1:0]  wstep;
   logic [15:0]    acc_r_nx, acc_g_nx, acc_b_nx;
   logic [23:0]    wheel_rgb;
   logic           wipe_adv;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr;
   logic [ledfx_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [ledfx_pkg::ENTRY_W-1:0]  ram_rdata;

   ledfx_ram #(
      .WIDTH (ledfx_pkg::ENTRY_W),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   // effective pixel count and speeds
   always_comb begin
      if (count_ff == 9'd0) begin
         n_eff = CW'(1);
      end else if (CW'(count_ff) > CW'(MAX_PIXELS)) begin
         n_eff = CW'(MAX_PIXELS);
      end else begin
         n_eff = CW'(count_ff);
      end
      if (wspeed_ff == 10'd0) begin
         wspeed_eff = 10'd1;
      end else if (wspeed_ff > ledfx_pkg::WIPE_SPEED_MAX) begin
         wspeed_eff = ledfx_pkg::WIPE_SPEED_MAX;
      end else begin
         wspeed_eff = wspeed_ff;
      end
      rspeed_eff = (rspeed_ff == 8'd0) ? 8'd1 : rspeed_ff;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = CW'(req_pixel_index) < n_eff;
   assign req_addr_ext = {{AW{1'b0}}, req_pixel_index};
   assign req_addr     = req_addr_ext[AW-1:0];

   // one restoring divide step per cycle, msb first
   assign div_t    = {rem_ff[RW-2:0], dvd_ff[DW-1]};
   assign div_ge   = div_t >= RW'(n_eff);
   assign div_rem  = div_ge ? (div_t - RW'(n_eff)) : div_t;
   assign quo_next = {quo_ff[6:0], div_ge};
   assign div_last = (cnt_ff == CNTW'(DW - 1));
   assign wstep    = (div_rem == RW'(0)) ? CW'(1) : div_rem[CW-1:0];

   assign wheel_rgb = ledfx_pkg::color_wheel(quo_next + phase_ff[11:4]);
   assign wipe_adv  = last_ff && (mode_ff == ledfx_pkg::MODE_WIPE);

   // one brightness bit per cycle, msb first
   assign acc_r_nx = (acc_r_ff << 1) + (mbr_ff[7] ? 16'(mc_r_ff) : 16'd0);
   assign acc_g_nx = (acc_g_ff << 1) + (mbr_ff[7] ? 16'(mc_g_ff) : 16'd0);
   assign acc_b_nx = (acc_b_ff << 1) + (mbr_ff[7] ? 16'(mc_b_ff) : 16'd0);

   // store write port: clearing pass or manual entry write
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = ledfx_pkg::ENTRY_RST;
      end else begin
         ram_we    = req_accept && (req_func == ledfx_pkg::FUNC_WRITE) && req_in_range;
         ram_waddr = req_addr;
         ram_wdata = {req_in_pixel_on, req_in_brightness, req_in_red, req_in_green, req_in_blue};
      end
   end

   // config register writes
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      rspeed_in = rspeed_ff;
      rfwd_in   = rfwd_ff;
      wspeed_in = wspeed_ff;
      wfwd_in   = wfwd_ff;
      base_in   = base_ff;
      if (csr_we) begin
         unique case (csr_index)
            ledfx_pkg::CSR_EFFECT_MODE:     mode_in   = csr_wdata[2:0];
            ledfx_pkg::CSR_PIXEL_COUNT:     count_in  = csr_wdata[8:0];
            ledfx_pkg::CSR_RAINBOW_SPEED:   rspeed_in = csr_wdata[7:0];
            ledfx_pkg::CSR_RAINBOW_FORWARD: rfwd_in   = csr_wdata[0];
            ledfx_pkg::CSR_WIPE_SPEED:      wspeed_in = csr_wdata[9:0];
            ledfx_pkg::CSR_WIPE_FORWARD:    wfwd_in   = csr_wdata[0];
            ledfx_pkg::CSR_BASE_COLOR:      base_in   = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      acc_r_in     = acc_r_ff;
      acc_g_in     = acc_g_ff;
      acc_b_in     = acc_b_ff;
      mc_r_in      = mc_r_ff;
      mc_g_in      = mc_g_ff;
      mc_b_in      = mc_b_ff;
      mbr_in       = mbr_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_end_in   = out_end_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAX_PIXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && (req_func != ledfx_pkg::FUNC_WRITE)) begin
               idx_in   = req_pixel_index;
               last_in  = req_frame_last;
               red_in   = 8'd0;
               green_in = 8'd0;
               blue_in  = 8'd0;
               rem_in   = RW'(0);
               quo_in   = 8'd0;
               cnt_in   = CNTW'(0);
               state_in = ST_DONE;
               if (req_in_range && (mode_ff == ledfx_pkg::MODE_RAINBOW)) begin
                  dvd_in   = DW'({req_pixel_index, 8'h00});
                  state_in = ST_DIV;
               end else if (req_in_range && (mode_ff == ledfx_pkg::MODE_MANUAL)) begin
                  state_in = ST_MLOAD;
               end else begin
                  if (req_in_range && (mode_ff == ledfx_pkg::MODE_WIPE) &&
                      (CW'(req_pixel_index) == CW'(pos_ff))) begin
                     red_in   = ledfx_pkg::LEVEL_FULL;
                     green_in = ledfx_pkg::LEVEL_FULL;
                     blue_in  = ledfx_pkg::LEVEL_FULL;
                  end
                  if (req_in_range && (mode_ff == ledfx_pkg::MODE_SOLID)) begin
                     red_in   = base_ff[23:16];
                     green_in = base_ff[15:8];
                     blue_in  = base_ff[7:0];
                  end
                  if (req_frame_last && (mode_ff == ledfx_pkg::MODE_WIPE)) begin
                     dvd_in   = DW'(wspeed_eff);
                     state_in = ST_WSTEP;
                  end
               end
            end
         end
         ST_DIV: begin
            dvd_in = dvd_ff << 1;
            rem_in = div_rem;
            quo_in = quo_next;
            cnt_in = cnt_ff + CNTW'(1);
            if (div_last) begin
               red_in   = wheel_rgb[23:16];
               green_in = wheel_rgb[15:8];
               blue_in  = wheel_rgb[7:0];
               state_in = ST_DONE;
            end
         end
         ST_MLOAD: begin
            mc_r_in  = ram_rdata[32] ? ram_rdata[23:16] : 8'd0;
            mc_g_in  = ram_rdata[32] ? ram_rdata[15:8] : 8'd0;
            mc_b_in  = ram_rdata[32] ? ram_rdata[7:0] : 8'd0;
            mbr_in   = ram_rdata[31:24];
            acc_r_in = 16'd0;
            acc_g_in = 16'd0;
            acc_b_in = 16'd0;
            cnt_in   = CNTW'(0);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_r_in = acc_r_nx;
            acc_g_in = acc_g_nx;
            acc_b_in = acc_b_nx;
            mbr_in   = mbr_ff << 1;
            cnt_in   = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(7)) begin
               red_in   = ledfx_pkg::div255(acc_r_nx);
               green_in = ledfx_pkg::div255(acc_g_nx);
               blue_in  = ledfx_pkg::div255(acc_b_nx);
               state_in = ST_DONE;
            end
         end
         ST_WSTEP: begin
            dvd_in = dvd_ff << 1;
            rem_in = div_rem;
            cnt_in = cnt_ff + CNTW'(1);
            if (div_last) begin
               if (wfwd_ff) begin
                  dvd_in = DW'(pos_ff) + DW'(wstep);
               end else begin
                  dvd_in = DW'(pos_ff) + DW'(n_eff) - DW'(wstep);
               end
               rem_in   = RW'(0);
               cnt_in   = CNTW'(0);
               state_in = ST_WPOS;
            end
         end
         ST_WPOS: begin
            dvd_in = dvd_ff << 1;
            rem_in = div_rem;
            cnt_in = cnt_ff + CNTW'(1);
            if (div_last) begin
               pos_in   = div_rem[AW-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_index_in = idx_ff;
               out_red_in   = red_ff;
               out_green_in = green_ff;
               out_blue_in  = blue_ff;
               out_end_in   = last_ff;
               if (last_ff && (mode_ff == ledfx_pkg::MODE_RAINBOW)) begin
                  if (rfwd_ff) begin
                     phase_in = phase_ff + 12'(rspeed_eff);
                  end else begin
                     phase_in = phase_ff - 12'(rspeed_eff);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // wipe_adv marks a beat that moves the wipe position at frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         mode_ff      <= ledfx_pkg::MODE_OFF;
         count_ff     <= ledfx_pkg::PIXEL_COUNT_RST;
         rspeed_ff    <= ledfx_pkg::RAINBOW_SPEED_RST;
         rfwd_ff      <= 1'b1;
         wspeed_ff    <= ledfx_pkg::WIPE_SPEED_RST;
         wfwd_ff      <= 1'b1;
         base_ff      <= ledfx_pkg::BASE_COLOR_RST;
         phase_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rspeed_ff    <= rspeed_in;
         rfwd_ff      <= rfwd_in;
         wspeed_ff    <= wspeed_in;
         wfwd_ff      <= wfwd_in;
         base_ff      <= base_in;
         phase_ff     <= phase_in;
         pos_ff       <= (state_ff == ST_WPOS && !wipe_adv) ? pos_ff : pos_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      acc_r_ff     <= acc_r_in;
      acc_g_ff     <= acc_g_in;
      acc_b_ff     <= acc_b_in;
      mc_r_ff      <= mc_r_in;
      mc_g_ff      <= mc_g_in;
      mc_b_ff      <= mc_b_in;
      mbr_ff       <= mbr_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      out_index_ff <= out_index_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_index     = out_index_ff;
   assign rsp_out_red       = out_red_ff;
   assign rsp_out_green     = out_green_ff;
   assign rsp_out_blue      = out_blue_ff;
   assign rsp_out_frame_end = out_end_ff;

endmodule
